FILE: rtl/sirstep_pkg.sv
// Shared types and constants for the SIR epidemic Euler step block.
`timescale 1ns / 1ps
`default_nettype none

package sirstep_pkg;

	// Configuration register widths and indexes.
	localparam int INF_RATE_W  = 16;
	localparam int REC_RATE_W  = 19;
	localparam int TSCALE_W    = 18;
	localparam int INIT_INF_W  = 4;
	localparam int CFG_DATA_W  = 19;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_INFECTION_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_INFECTED = 2'd3;

	localparam logic [INF_RATE_W-1:0] INF_RATE_RESET = 16'd6554;
	localparam logic [REC_RATE_W-1:0] REC_RATE_RESET = 19'd65536;
	localparam logic [TSCALE_W-1:0]   TSCALE_RESET   = 18'd65536;
	localparam logic [INIT_INF_W-1:0] INIT_INF_RESET = 4'd1;

	// Model constants.
	localparam int POPULATION     = 100;
	localparam int RESET_INFECTED = 2;
	localparam int SAT_INT        = 255;
	localparam int RATE_FRAC      = 16;
	localparam int DT_RECIP       = 10000;
	localparam int DT_RECIP_BITS  = 14;

	// Multiplier slice width of the shared unit.
	localparam int CHUNK_W = 8;

	// Level output: floor(t / 10) as (t * LVL_RECIP) >> LVL_SHIFT for t <= LVL_T_MAX.
	localparam int LEVEL_W    = 16;
	localparam int LVL_Q_BITS = 12;
	localparam int LVL_T_W    = 19;
	localparam int LVL_T_MAX  = 409600;
	localparam int LVL_RECIP  = 838861;
	localparam int LVL_SHIFT  = 23;

	// Sequencer states: idle, one per product, plus update and hand-off.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SI,
		ST_INF,
		ST_REC,
		ST_DIK,
		ST_DIDIV,
		ST_DRK,
		ST_DRDIV,
		ST_UPDATE,
		ST_LVS,
		ST_LVI,
		ST_LVR,
		ST_OUT
	} st_t;

	// Control bundle from the sequencer to the datapath.
	typedef struct packed {
		st_t  state;
		logic in_ready;
		logic mac_start;
		logic capture;
		logic out_load;
	} ctl_t;

endpackage

`default_nettype wire

FILE: rtl/sirstep_mac.sv
// Shared multiply-accumulate unit that forms one product a slice of the multiplier per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sirstep_mac
	import sirstep_pkg::*;
#(
	parameter int AW = 42,
	parameter int MW = 43
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [AW-1:0]    a,
	input  wire logic [MW-1:0]    b,
	output logic                  done,
	output logic [AW+MW-1:0]      prod
);

	localparam int PW = AW + MW;

	logic [PW-1:0]         a_q;
	logic [MW-1:0]         b_q;
	logic [PW-1:0]         acc_q;
	logic                  busy_q;
	logic                  done_q;
	logic [PW+CHUNK_W-1:0] pp;
	logic                  last;

	// Partial product of the shifted multiplicand and the lowest remaining slice.
	assign pp   = a_q * b_q[CHUNK_W-1:0];
	assign last = (b_q[MW-1:CHUNK_W] == '0);

	// Control: busy while slices remain, then a one-cycle done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand shifting and accumulation.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PW'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp[PW-1:0];
			a_q   <= a_q << CHUNK_W;
			b_q   <= b_q >> CHUNK_W;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (!busy_q && !done_q))
		else $error("multiply started while the unit was busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("done raised while still accumulating");
`endif

endmodule

`default_nettype wire

FILE: rtl/sirstep_ctrl.sv
// Sequencer that steps the shared multiplier through the products of one Euler step.
`timescale 1ns / 1ps
`default_nettype none

module sirstep_ctrl
	import sirstep_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic mac_done,
	input  wire logic out_free,
	output ctl_t      ctl
);

	st_t  state_q;
	st_t  state_d;
	logic issued_q;
	logic is_mac;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_SI;
			ST_SI:     if (mac_done) state_d = ST_INF;
			ST_INF:    if (mac_done) state_d = ST_REC;
			ST_REC:    if (mac_done) state_d = ST_DIK;
			ST_DIK:    if (mac_done) state_d = ST_DIDIV;
			ST_DIDIV:  if (mac_done) state_d = ST_DRK;
			ST_DRK:    if (mac_done) state_d = ST_DRDIV;
			ST_DRDIV:  if (mac_done) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_LVS;
			ST_LVS:    if (mac_done) state_d = ST_LVI;
			ST_LVI:    if (mac_done) state_d = ST_LVR;
			ST_LVR:    if (mac_done) state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		unique case (state_q) inside
			ST_SI, ST_INF, ST_REC, ST_DIK, ST_DIDIV, ST_DRK, ST_DRDIV,
			ST_LVS, ST_LVI, ST_LVR: is_mac = 1'b1;
			default:                is_mac = 1'b0;
		endcase
		ctl.state     = state_q;
		ctl.in_ready  = (state_q == ST_IDLE);
		ctl.mac_start = is_mac && !issued_q;
		ctl.capture   = is_mac && mac_done;
		ctl.out_load  = (state_q == ST_OUT) && out_free;
	end

	// State and launch flag; the flag makes each product start exactly once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.mac_start) begin
				issued_q <= 1'b1;
			end else if (mac_done) begin
				issued_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sir_epidemic_euler_step.sv
// Top level of the SIR epidemic forward Euler step block.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transfer advances a susceptible/infected/recovered model by one
// forward Euler step (dt of 0.0001, population 100, state in signed fixed point
// with FRAC_BITS fraction bits, saturating at +-255) and returns the three
// populations divided by ten as 0..10 V levels in Q4.12. A restart of 1 reloads
// the initial populations before the step. All ten products of a step (five for
// the update, two reciprocal multiplies for the division by 10000, three for the
// level scaling) run in turn on one shared multiply-accumulate unit that takes
// eight bits of its multiplier per cycle, so a product lasts longer the more
// significant bytes its multiplier operand has. Steps are longest at the reset
// settings while the output register is free. Small rates, a small time scale
// or a small infected count shorten a step, and a result that is still waiting
// in the output register delays the next transfer until it is taken. The
// input is not ready during a step. A finished result waits in the output
// register while the next item is accepted.
module sir_epidemic_euler_step
	import sirstep_pkg::*;
#(
	parameter int FRAC_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  restart,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [LEVEL_W-1:0]         susceptible_level,
	output logic [LEVEL_W-1:0]         infected_level,
	output logic [LEVEL_W-1:0]         recovered_level
);

	localparam int SW     = FRAC_BITS + 9;
	localparam int MAGW   = FRAC_BITS + 8;
	localparam int SIW    = FRAC_BITS + 16;
	localparam int RECW   = FRAC_BITS + 11;
	localparam int NW     = FRAC_BITS + 18;
	localparam int MW     = NW + 1;
	localparam int PW     = NW + MW;
	localparam int DW     = FRAC_BITS + 5;
	localparam int EW     = FRAC_BITS + 12;
	localparam int DIV_SH = NW + DT_RECIP_BITS;

	localparam logic [63:0] DIV_RECIP_FULL = ((64'd1 << DIV_SH) / 64'(DT_RECIP)) + 64'd1;
	localparam logic [MW-1:0] DIV_RECIP = DIV_RECIP_FULL[MW-1:0];

	localparam logic signed [SW-1:0] STATE_LIM = signed'(SW'(SAT_INT) << FRAC_BITS);
	localparam logic signed [SW-1:0] S_RESET =
		signed'(SW'(POPULATION - RESET_INFECTED) << FRAC_BITS);
	localparam logic signed [SW-1:0] I_RESET = signed'(SW'(RESET_INFECTED) << FRAC_BITS);

	// Saturate a widened state value to +-255.
	function automatic logic signed [SW-1:0] sat_state(input logic signed [EW-1:0] v);
		if (v > EW'(STATE_LIM)) return STATE_LIM;
		if (v < -EW'(STATE_LIM)) return -STATE_LIM;
		return SW'(v);
	endfunction

	// Scale a state to the level numerator, zero for non-positive values, clamped.
	function automatic logic [LVL_T_W-1:0] lvl_arg(input logic signed [SW-1:0] x);
		logic [LVL_T_W:0] t;
		t = x[SW-2 -: LVL_T_W+1];
		if (x[SW-1] || (x == '0)) return '0;
		if (t > (LVL_T_W+1)'(LVL_T_MAX)) return LVL_T_W'(LVL_T_MAX);
		return t[LVL_T_W-1:0];
	endfunction

	ctl_t ctl;

	logic [INF_RATE_W-1:0] inf_rate_q;
	logic [REC_RATE_W-1:0] rec_rate_q;
	logic [TSCALE_W-1:0]   tscale_q;
	logic [INIT_INF_W-1:0] init_inf_q;

	logic signed [SW-1:0] susc_q;
	logic signed [SW-1:0] infd_q;
	logic signed [SW-1:0] recv_q;

	logic [SIW-1:0]  si_q;
	logic [SIW-1:0]  inf_q;
	logic [RECW-1:0] rec_q;
	logic [NW-1:0]   n_q;
	logic [DW-1:0]   di_q;
	logic [DW-1:0]   dr_q;

	logic [LEVEL_W-1:0] lvl_s_q;
	logic [LEVEL_W-1:0] lvl_i_q;
	logic [LEVEL_W-1:0] lvl_r_q;
	logic [LEVEL_W-1:0] out_s_q;
	logic [LEVEL_W-1:0] out_i_q;
	logic [LEVEL_W-1:0] out_r_q;
	logic               out_valid_q;

	logic [SW-1:0]   s_abs;
	logic [SW-1:0]   i_abs;
	logic [MAGW-1:0] s_mag;
	logic [MAGW-1:0] i_mag;
	logic            si_neg;
	logic            i_neg;

	logic [NW-1:0]   mac_a;
	logic [MW-1:0]   mac_b;
	logic            mac_done;
	logic [PW-1:0]   prod;
	logic            out_free;

	logic [INIT_INF_W-1:0] i0_eff;
	logic [6:0]            s0_int;

	logic signed [EW-1:0] di_sg;
	logic signed [EW-1:0] dr_sg;
	logic signed [EW-1:0] s_next;
	logic signed [EW-1:0] i_next;
	logic signed [EW-1:0] r_next;

	sirstep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mac_done (mac_done),
		.out_free (out_free),
		.ctl      (ctl)
	);

	sirstep_mac #(
		.AW (NW),
		.MW (MW)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.mac_start),
		.a      (mac_a),
		.b      (mac_b),
		.done   (mac_done),
		.prod   (prod)
	);

	assign in_ready = ctl.in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Magnitudes and signs of the current state.
	assign s_abs  = susc_q[SW-1] ? SW'(-susc_q) : SW'(susc_q);
	assign i_abs  = infd_q[SW-1] ? SW'(-infd_q) : SW'(infd_q);
	assign s_mag  = s_abs[MAGW-1:0];
	assign i_mag  = i_abs[MAGW-1:0];
	assign si_neg = susc_q[SW-1] ^ infd_q[SW-1];
	assign i_neg  = infd_q[SW-1];

	// Operand selection for the shared unit.
	always_comb begin
		unique case (ctl.state) inside
			ST_SI: begin
				mac_a = NW'(s_mag);
				mac_b = MW'(i_mag);
			end
			ST_INF: begin
				mac_a = NW'(si_q);
				mac_b = MW'(inf_rate_q);
			end
			ST_REC: begin
				mac_a = NW'(i_mag);
				mac_b = MW'(rec_rate_q);
			end
			ST_DIK: begin
				mac_a = NW'(inf_q);
				mac_b = MW'(tscale_q);
			end
			ST_DRK: begin
				mac_a = NW'(rec_q);
				mac_b = MW'(tscale_q);
			end
			ST_DIDIV, ST_DRDIV: begin
				mac_a = n_q;
				mac_b = DIV_RECIP;
			end
			ST_LVS: begin
				mac_a = NW'(lvl_arg(susc_q));
				mac_b = MW'(LVL_RECIP);
			end
			ST_LVI: begin
				mac_a = NW'(lvl_arg(infd_q));
				mac_b = MW'(LVL_RECIP);
			end
			ST_LVR: begin
				mac_a = NW'(lvl_arg(recv_q));
				mac_b = MW'(LVL_RECIP);
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase
	end

	// Product capture, each rescaled to its format.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			case (ctl.state) inside
				ST_SI:            si_q    <= prod[FRAC_BITS +: SIW];
				ST_INF:           inf_q   <= prod[RATE_FRAC +: SIW];
				ST_REC:           rec_q   <= prod[RATE_FRAC +: RECW];
				ST_DIK, ST_DRK:   n_q     <= prod[RATE_FRAC +: NW];
				ST_DIDIV:         di_q    <= prod[DIV_SH +: DW];
				ST_DRDIV:         dr_q    <= prod[DIV_SH +: DW];
				ST_LVS:           lvl_s_q <= prod[LVL_SHIFT +: LEVEL_W];
				ST_LVI:           lvl_i_q <= prod[LVL_SHIFT +: LEVEL_W];
				ST_LVR:           lvl_r_q <= prod[LVL_SHIFT +: LEVEL_W];
				default: ;
			endcase
		end
	end

	// Signed increments and the new state before saturation.
	always_comb begin
		di_sg  = si_neg ? -signed'(EW'(di_q)) : signed'(EW'(di_q));
		dr_sg  = i_neg ? -signed'(EW'(dr_q)) : signed'(EW'(dr_q));
		s_next = EW'(susc_q) - di_sg;
		i_next = EW'(infd_q) + di_sg - dr_sg;
		r_next = EW'(recv_q) + dr_sg;
	end

	// Restart populations; an initial count of zero counts as one.
	assign i0_eff = (init_inf_q == '0) ? INIT_INF_W'(1) : init_inf_q;
	assign s0_int = 7'(POPULATION) - 7'(i0_eff);

	// Population state: reload on a restart transfer, update after the update and division products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			susc_q <= S_RESET;
			infd_q <= I_RESET;
			recv_q <= '0;
		end else if (in_valid && ctl.in_ready && restart) begin
			susc_q <= signed'(SW'(s0_int) << FRAC_BITS);
			infd_q <= signed'(SW'(i0_eff) << FRAC_BITS);
			recv_q <= '0;
		end else if (ctl.state == ST_UPDATE) begin
			susc_q <= sat_state(s_next);
			infd_q <= sat_state(i_next);
			recv_q <= sat_state(r_next);
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_rate_q <= INF_RATE_RESET;
			rec_rate_q <= REC_RATE_RESET;
			tscale_q   <= TSCALE_RESET;
			init_inf_q <= INIT_INF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INFECTION_RATE:   inf_rate_q <= cfg_data[INF_RATE_W-1:0];
				CFG_RECOVERY_RATE:    rec_rate_q <= cfg_data[REC_RATE_W-1:0];
				CFG_TIME_SCALE:       tscale_q   <= cfg_data[TSCALE_W-1:0];
				CFG_INITIAL_INFECTED: init_inf_q <= cfg_data[INIT_INF_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_s_q <= lvl_s_q;
			out_i_q <= lvl_i_q;
			out_r_q <= lvl_r_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign susceptible_level = out_s_q;
	assign infected_level    = out_i_q;
	assign recovered_level   = out_r_q;

`ifndef SYNTHESIS
	a_state_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(susc_q <= STATE_LIM) && (susc_q >= -STATE_LIM) &&
		(infd_q <= STATE_LIM) && (infd_q >= -STATE_LIM) &&
		(recv_q <= STATE_LIM) && (recv_q >= -STATE_LIM))
		else $error("population state beyond saturation limit");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_s_q <= LEVEL_W'(40960)) && (out_i_q <= LEVEL_W'(40960)) &&
		(out_r_q <= LEVEL_W'(40960))))
		else $error("output level above ten volts");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && ctl.in_ready) |=> !ctl.in_ready)
		else $error("input still ready after a transfer was taken");
`endif

endmodule

`default_nettype wire
